// ===== src/gbs_pkg.sv =====
// Shared constants, codes and types of the graph search block.
package gbs_pkg;

  localparam int NODES      = 32;
  localparam int DEGREE     = 2;
  localparam int IDX_W      = 5;                    // node index width (ports)
  localparam int VAL_W      = 32;                   // node value width
  localparam int SLOT_W     = $clog2(DEGREE);       // slot address bits
  localparam int SC_W       = $clog2(DEGREE + 1);   // slot counter, holds DEGREE
  localparam int PTR_W      = $clog2(NODES + 1);    // list pointer, holds NODES
  localparam int LA_W       = IDX_W + SLOT_W;       // link memory address
  localparam int LINK_DEPTH = NODES << SLOT_W;
  localparam int WL_W       = IDX_W + SC_W;         // work list entry {node, slot}
  localparam int ADDR_W     = 4;                    // config byte address

  // request codes
  localparam logic [1:0] REQ_VALUE  = 2'd0;
  localparam logic [1:0] REQ_LINK   = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;
  localparam logic [1:0] REG_STOP   = 2'd2;

  // search modes
  localparam logic MODE_BFS = 1'b0;
  localparam logic MODE_DFS = 1'b1;

  localparam logic signed [VAL_W-1:0] TARGET_RESET = 32'sd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BFS_POP,
    ST_BFS_READ,
    ST_BFS_VISIT,
    ST_BFS_LINK,
    ST_DFS_ROOT,
    ST_DFS_TOP,
    ST_DFS_LINK,
    ST_DFS_VISIT,
    ST_DFS_POPRD,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic                     search_mode;
    logic signed [VAL_W-1:0]  target_value;
    logic                     stop_on_match;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  value;
    logic                     found;
  } visit_t;

endpackage

// ===== src/graph_bfs_dfs_search.sv =====
// Top level of the breadth-first / depth-first graph search block.
//
// Stores a graph of 32 nodes, each with a 32-bit value and two ordered
// neighbor slots (an absent slot ends the list), and walks it from a root on
// request. Items enter on start while busy is low. A value write
// (req_type 0) or link write (req_type 1) leaves busy low.
// A search (req_type 2) raises busy for the whole walk. Visits come out on
// visit_strobe, one cycle each, in breadth-first order (search_mode 0, a
// queue in a work-list memory) or depth-first pre-order (search_mode 1, a
// stack of {node, next slot} frames in the same memory). The receiver cannot
// stall: every strobe is a transfer. The last visit of a search carries
// last = 1, and found marks a visit whose value equals target_value; with
// stop_on_match set the walk ends on the first such visit. The node-value,
// link and work-list memories have registered reads. busy drops in the
// cycle that the final result is shown. Node values never written read
// back as undefined. Config registers sit at byte addresses 0 (search_mode),
// 4 (target_value) and 8 (stop_on_match); the user must see that they are
// written only while busy is low, since the block does not enforce it.
module graph_bfs_dfs_search (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type,
  input  logic [gbs_pkg::IDX_W-1:0]         node_index,
  input  logic signed [gbs_pkg::VAL_W-1:0]  node_value,
  input  logic                              neighbor_slot,
  input  logic [gbs_pkg::IDX_W-1:0]         neighbor_index,
  input  logic                              neighbor_present,
  // results
  output logic                              visit_strobe,
  output logic [gbs_pkg::IDX_W-1:0]         visit_index,
  output logic signed [gbs_pkg::VAL_W-1:0]  visit_value,
  output logic                              found,
  output logic                              last,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gbs_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import gbs_pkg::*;

  cfg_t   cfg;
  visit_t vis;
  logic   flush;

  assign pready = 1'b1;

  gbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  gbs_walk u_walk (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .start            (start),
    .req_type         (req_type),
    .node_index       (node_index),
    .node_value       (node_value),
    .neighbor_slot    (neighbor_slot),
    .neighbor_index   (neighbor_index),
    .neighbor_present (neighbor_present),
    .busy             (busy),
    .vis              (vis),
    .flush            (flush)
  );

  gbs_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .vis          (vis),
    .flush        (flush),
    .visit_strobe (visit_strobe),
    .visit_index  (visit_index),
    .visit_value  (visit_value),
    .found        (found),
    .last         (last)
  );

`ifndef ASSERT_OFF
  // results only come out of a walk in progress
  a_strobe_in_walk: assert property (@(posedge clk) disable iff (rst)
    visit_strobe |-> $past(busy))
    else $error("visit result outside a search");

  // the final result coincides with the return to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    visit_strobe && last |-> !busy)
    else $error("last result while still busy");

  // every search request starts a walk
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_SEARCH |=> busy)
    else $error("search did not start");

  // load writes leave the block idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == REQ_VALUE || req_type == REQ_LINK) |=> !busy)
    else $error("load write left the block busy");
`endif

endmodule

// ===== src/gbs_regs.sv =====
// APB configuration registers of the graph search block.
module gbs_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output gbs_pkg::cfg_t             cfg
);
  import gbs_pkg::*;

  logic wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_mode   <= MODE_BFS;
      cfg.target_value  <= TARGET_RESET;
      cfg.stop_on_match <= 1'b1;
    end else if (wr) begin
      case (paddr[3:2])
        REG_MODE:   cfg.search_mode   <= pwdata[0];
        REG_TARGET: cfg.target_value  <= pwdata;
        REG_STOP:   cfg.stop_on_match <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {31'b0, cfg.search_mode};
      REG_TARGET: prdata = cfg.target_value;
      REG_STOP:   prdata = {31'b0, cfg.stop_on_match};
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== src/gbs_walk.sv =====
// Graph memories and the breadth-first / depth-first walk sequencer.
module gbs_walk (
  input  logic                              clk,
  input  logic                              rst,
  input  gbs_pkg::cfg_t                     cfg,
  input  logic                              start,
  input  logic [1:0]                        req_type,
  input  logic [gbs_pkg::IDX_W-1:0]         node_index,
  input  logic signed [gbs_pkg::VAL_W-1:0]  node_value,
  input  logic                              neighbor_slot,
  input  logic [gbs_pkg::IDX_W-1:0]         neighbor_index,
  input  logic                              neighbor_present,
  output logic                              busy,
  output gbs_pkg::visit_t                   vis,
  output logic                              flush
);
  import gbs_pkg::*;

  state_t            state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;      // queue tail, or stack depth in DFS
  logic [IDX_W-1:0]  cur_node, cur_node_next;
  logic [SC_W-1:0]   cur_slot, cur_slot_next;
  logic [IDX_W-1:0]  nb_reg, nb_reg_next;
  logic [NODES-1:0]  visited, visited_next;

  // node values
  logic [VAL_W-1:0]  val_mem [NODES];
  logic              val_we, val_re;
  logic [IDX_W-1:0]  val_waddr, val_raddr;
  logic [VAL_W-1:0]  val_wdata, val_rdata;

  // neighbor links: target in memory, presence in flops
  logic [IDX_W-1:0]      lnk_mem [LINK_DEPTH];
  logic [LINK_DEPTH-1:0] link_ok;
  logic                  lnk_we, lnk_re, lnk_ok_wdata;
  logic [LA_W-1:0]       lnk_waddr, lnk_raddr;
  logic [IDX_W-1:0]      lnk_rdata;

  // work list: queue or stack of {node, next slot}
  logic [WL_W-1:0]   wl_mem [NODES];
  logic              wl_we, wl_re;
  logic [IDX_W-1:0]  wl_waddr, wl_raddr;
  logic [WL_W-1:0]   wl_wdata, wl_rdata;

  logic              accept, node_ok, slot_ok, match, stop_hit, top_ok, room;
  logic [LA_W-1:0]   top_addr;
  logic [SC_W-1:0]   slot_inc;
  logic [PTR_W-1:0]  tail_m1, tail_m2;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign node_ok  = {1'b0, node_index} < PTR_W'(NODES);
  assign slot_ok  = SC_W'(neighbor_slot) < SC_W'(DEGREE);
  assign match    = (val_rdata == cfg.target_value);
  assign stop_hit = match && cfg.stop_on_match;
  assign top_addr = {cur_node, cur_slot[SLOT_W-1:0]};
  assign top_ok   = link_ok[top_addr];
  assign slot_inc = cur_slot + 1'b1;
  assign room     = tail < PTR_W'(NODES);
  assign tail_m1  = tail - 1'b1;
  assign tail_m2  = tail - 2'd2;
  assign lnk_ok_wdata = neighbor_present && ({1'b0, neighbor_index} < PTR_W'(NODES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      tail     <= '0;
      visited  <= '0;
      cur_node <= '0;
      cur_slot <= '0;
      nb_reg   <= '0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      visited  <= visited_next;
      cur_node <= cur_node_next;
      cur_slot <= cur_slot_next;
      nb_reg   <= nb_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_ok <= '0;
    end else if (lnk_we) begin
      link_ok[lnk_waddr] <= lnk_ok_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    if (val_re) val_rdata <= val_mem[val_raddr];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) lnk_mem[lnk_waddr] <= neighbor_index;
    if (lnk_re) lnk_rdata <= lnk_mem[lnk_raddr];
  end

  always_ff @(posedge clk) begin
    if (wl_we) wl_mem[wl_waddr] <= wl_wdata;
    if (wl_re) wl_rdata <= wl_mem[wl_raddr];
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    visited_next  = visited;
    cur_node_next = cur_node;
    cur_slot_next = cur_slot;
    nb_reg_next   = nb_reg;
    val_we        = 1'b0;
    val_waddr     = node_index;
    val_wdata     = node_value;
    val_re        = 1'b0;
    val_raddr     = cur_node;
    lnk_we        = 1'b0;
    lnk_waddr     = {node_index, neighbor_slot};
    lnk_re        = 1'b0;
    lnk_raddr     = top_addr;
    wl_we         = 1'b0;
    wl_waddr      = '0;
    wl_wdata      = '0;
    wl_re         = 1'b0;
    wl_raddr      = '0;
    vis.valid     = 1'b0;
    vis.index     = cur_node;
    vis.value     = val_rdata;
    vis.found     = match;
    flush         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_VALUE: val_we = node_ok;
            REQ_LINK:  lnk_we = node_ok && slot_ok;
            REQ_SEARCH: begin
              if (node_ok) begin
                visited_next             = '0;
                visited_next[node_index] = 1'b1;
                cur_node_next            = node_index;
                cur_slot_next            = '0;
                if (cfg.search_mode == MODE_DFS) begin
                  val_re     = 1'b1;
                  val_raddr  = node_index;
                  state_next = ST_DFS_ROOT;
                end else begin
                  wl_we      = 1'b1;
                  wl_waddr   = '0;
                  wl_wdata   = {node_index, SC_W'(0)};
                  head_next  = '0;
                  tail_next  = PTR_W'(1);
                  state_next = ST_BFS_POP;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_BFS_POP: begin
        if (head < tail) begin
          wl_re      = 1'b1;
          wl_raddr   = head[IDX_W-1:0];
          head_next  = head + 1'b1;
          state_next = ST_BFS_READ;
        end else begin
          state_next = ST_FLUSH;
        end
      end

      ST_BFS_READ: begin
        cur_node_next = wl_rdata[WL_W-1:SC_W];
        cur_slot_next = '0;
        val_re        = 1'b1;
        val_raddr     = wl_rdata[WL_W-1:SC_W];
        lnk_re        = 1'b1;
        lnk_raddr     = {wl_rdata[WL_W-1:SC_W], SLOT_W'(0)};
        state_next    = ST_BFS_VISIT;
      end

      ST_BFS_VISIT: begin
        vis.valid  = 1'b1;
        state_next = stop_hit ? ST_FLUSH : ST_BFS_LINK;
      end

      // one slot per cycle; link data for the current slot is already in lnk_rdata
      ST_BFS_LINK: begin
        if (!top_ok) begin
          state_next = ST_BFS_POP;
        end else begin
          if (!visited[lnk_rdata] && room) begin
            visited_next[lnk_rdata] = 1'b1;
            wl_we     = 1'b1;
            wl_waddr  = tail[IDX_W-1:0];
            wl_wdata  = {lnk_rdata, SC_W'(0)};
            tail_next = tail + 1'b1;
          end
          cur_slot_next = slot_inc;
          if (slot_inc == SC_W'(DEGREE)) begin
            state_next = ST_BFS_POP;
          end else begin
            lnk_re    = 1'b1;
            lnk_raddr = {cur_node, slot_inc[SLOT_W-1:0]};
          end
        end
      end

      ST_DFS_ROOT: begin
        vis.valid = 1'b1;
        if (stop_hit) begin
          state_next = ST_FLUSH;
        end else begin
          tail_next  = PTR_W'(1);
          state_next = ST_DFS_TOP;
        end
      end

      // top frame lives in cur_node/cur_slot; frames below it in wl_mem
      ST_DFS_TOP: begin
        if (cur_slot == SC_W'(DEGREE) || !top_ok) begin
          tail_next = tail_m1;
          if (tail == PTR_W'(1)) begin
            state_next = ST_FLUSH;
          end else begin
            wl_re      = 1'b1;
            wl_raddr   = tail_m2[IDX_W-1:0];
            state_next = ST_DFS_POPRD;
          end
        end else begin
          lnk_re     = 1'b1;
          lnk_raddr  = top_addr;
          state_next = ST_DFS_LINK;
        end
      end

      ST_DFS_LINK: begin
        cur_slot_next = slot_inc;
        if (!visited[lnk_rdata] && room) begin
          visited_next[lnk_rdata] = 1'b1;
          val_re      = 1'b1;
          val_raddr   = lnk_rdata;
          nb_reg_next = lnk_rdata;
          state_next  = ST_DFS_VISIT;
        end else begin
          state_next  = ST_DFS_TOP;
        end
      end

      ST_DFS_VISIT: begin
        vis.valid = 1'b1;
        vis.index = nb_reg;
        if (stop_hit) begin
          state_next = ST_FLUSH;
        end else begin
          wl_we         = 1'b1;
          wl_waddr      = tail_m1[IDX_W-1:0];
          wl_wdata      = {cur_node, cur_slot};
          cur_node_next = nb_reg;
          cur_slot_next = '0;
          tail_next     = tail + 1'b1;
          state_next    = ST_DFS_TOP;
        end
      end

      ST_DFS_POPRD: begin
        cur_node_next = wl_rdata[WL_W-1:SC_W];
        cur_slot_next = wl_rdata[SC_W-1:0];
        state_next    = ST_DFS_TOP;
      end

      ST_FLUSH: begin
        flush      = 1'b1;
        state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/gbs_emit.sv =====
// Result stage: holds one visit back so the final one can be marked last.
module gbs_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  gbs_pkg::visit_t                   vis,
  input  logic                              flush,
  output logic                              visit_strobe,
  output logic [gbs_pkg::IDX_W-1:0]         visit_index,
  output logic signed [gbs_pkg::VAL_W-1:0]  visit_value,
  output logic                              found,
  output logic                              last
);
  import gbs_pkg::*;

  logic                     pend_valid;
  logic [IDX_W-1:0]         pend_index;
  logic signed [VAL_W-1:0]  pend_value;
  logic                     pend_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      visit_strobe <= 1'b0;
    end else begin
      visit_strobe <= 1'b0;
      if (vis.valid) begin
        // a newer visit exists, so the held one is not the last
        visit_strobe <= pend_valid;
        pend_valid   <= 1'b1;
      end else if (flush) begin
        visit_strobe <= pend_valid;
        pend_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vis.valid) begin
      pend_index <= vis.index;
      pend_value <= vis.value;
      pend_found <= vis.found;
    end
    if (vis.valid || flush) begin
      visit_index <= pend_index;
      visit_value <= pend_value;
      found       <= pend_found;
      last        <= !vis.valid;
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for graph_bfs_dfs_search: loads graphs, walks them, checks every visit.
`timescale 1ns / 100ps

module testbench;
  import gbs_pkg::*;

  // req_type 3 has no meaning; the block drops it without a result
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEM_GOAL = 470;

  // one visit as it should appear on the result ports
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
    logic                    fnd;
    logic                    lst;
  } visit_rec_t;

  // Mirror of the stored graph and the registers; walks the graph the same
  // way the block does and keeps the visits that are still to come out.
  class walk_checker;
    logic signed [VAL_W-1:0] node_val [NODES];
    bit                      written [NODES];
    bit                      link_ok [NODES][DEGREE];
    bit [IDX_W-1:0]          link_to [NODES][DEGREE];
    bit                      mode;
    logic signed [VAL_W-1:0] target;
    bit                      stop;
    visit_rec_t              expected_visits [$];
    int                      bad_visits;

    function new();
      foreach (node_val[i]) begin
        node_val[i] = '0;
        written[i]  = 1'b0;
        for (int s = 0; s < DEGREE; s++) begin
          link_ok[i][s] = 1'b0;
          link_to[i][s] = '0;
        end
      end
      mode       = MODE_BFS;
      target     = TARGET_RESET;
      stop       = 1'b1;
      bad_visits = 0;
    endfunction

    function void set_reg(logic [1:0] r, logic [31:0] d);
      case (r)
        REG_MODE:   mode = d[0];
        REG_TARGET: target = d;
        REG_STOP:   stop = d[0];
        default: ;
      endcase
    endfunction

    // queues one visit; tells the walk to end on a match when stopping
    function bit add_visit(int n);
      visit_rec_t r;
      r.idx = n[IDX_W-1:0];
      r.val = node_val[n];
      r.fnd = (node_val[n] == target);
      r.lst = 1'b0;
      expected_visits.push_back(r);
      return r.fnd && stop;
    endfunction

    function void walk_breadth(int root);
      bit seen [NODES];
      int order [NODES];
      int head, tail, cur, nb;
      foreach (seen[i]) seen[i] = 1'b0;
      head = 0;
      tail = 1;
      seen[root] = 1'b1;
      order[0] = root;
      while (head < tail) begin
        cur = order[head];
        head++;
        if (add_visit(cur)) return;
        for (int s = 0; s < DEGREE; s++) begin
          if (!link_ok[cur][s]) break;   // absent slot ends the list
          nb = link_to[cur][s];
          if (!seen[nb] && tail < NODES) begin
            seen[nb] = 1'b1;
            order[tail] = nb;
            tail++;
          end
        end
      end
    endfunction

    // pre-order with {node, next slot} frames
    function void walk_depth(int root);
      bit seen [NODES];
      int frame_node [NODES];
      int frame_slot [NODES];
      int depth, cur, s, nb;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[root] = 1'b1;
      if (add_visit(root)) return;
      frame_node[0] = root;
      frame_slot[0] = 0;
      depth = 1;
      while (depth > 0) begin
        cur = frame_node[depth-1];
        s   = frame_slot[depth-1];
        if (s >= DEGREE || !link_ok[cur][s]) begin
          depth--;
        end else begin
          frame_slot[depth-1] = s + 1;
          nb = link_to[cur][s];
          if (!seen[nb] && depth < NODES) begin
            seen[nb] = 1'b1;
            if (add_visit(nb)) return;
            frame_node[depth] = nb;
            frame_slot[depth] = 0;
            depth++;
          end
        end
      end
    endfunction

    function void accept_item(logic [1:0] rq, logic [IDX_W-1:0] ni,
                              logic signed [VAL_W-1:0] nv, logic sl,
                              logic [IDX_W-1:0] nbi, logic pr);
      int base;
      visit_rec_t r;
      base = expected_visits.size();
      case (rq)
        REQ_VALUE: begin
          node_val[ni] = nv;
          written[ni]  = 1'b1;
        end
        REQ_LINK: begin
          link_ok[ni][sl] = pr;
          link_to[ni][sl] = pr ? nbi : '0;
        end
        REQ_SEARCH: begin
          if (mode == MODE_DFS) walk_depth(ni);
          else walk_breadth(ni);
          if (expected_visits.size() > base) begin
            r = expected_visits.pop_back();
            r.lst = 1'b1;
            expected_visits.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_visit(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
                              logic fnd, logic lst);
      visit_rec_t e;
      if (expected_visits.size() == 0) begin
        bad_visits++;
        if (bad_visits <= 10)
          $display("%0t: unexpected visit: node %0d value %0d found %b last %b",
                   $realtime, idx, val, fnd, lst);
        return;
      end
      e = expected_visits.pop_front();
      if (idx !== e.idx || val !== e.val || fnd !== e.fnd || lst !== e.lst) begin
        bad_visits++;
        if (bad_visits <= 10)
          $display("%0t: visit mismatch: want node %0d value %0d found %b last %b,%s",
                   $realtime, e.idx, e.val, e.fnd, e.lst,
                   $sformatf(" got node %0d value %0d found %b last %b",
                             idx, val, fnd, lst));
      end
    endfunction

    // first node reachable from root whose value was never set, or -1
    function int unwritten_in_reach(int root);
      bit seen [NODES];
      int order [NODES];
      int head, tail, cur, nb;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[root] = 1'b1;
      order[0] = root;
      head = 0;
      tail = 1;
      while (head < tail) begin
        cur = order[head];
        head++;
        if (!written[cur]) return cur;
        for (int s = 0; s < DEGREE; s++) begin
          if (!link_ok[cur][s]) break;
          nb = link_to[cur][s];
          if (!seen[nb]) begin
            seen[nb] = 1'b1;
            order[tail] = nb;
            tail++;
          end
        end
      end
      return -1;
    endfunction
  endclass

  // ---------------------------------------------------------------- signals
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               req_type = REQ_VALUE;
  logic [IDX_W-1:0]         node_index = '0;
  logic signed [VAL_W-1:0]  node_value = '0;
  logic                     neighbor_slot = 1'b0;
  logic [IDX_W-1:0]         neighbor_index = '0;
  logic                     neighbor_present = 1'b0;
  logic                     visit_strobe;
  logic [IDX_W-1:0]         visit_index;
  logic signed [VAL_W-1:0]  visit_value;
  logic                     found;
  logic                     last;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  walk_checker walks = new();
  int          items_sent = 0;   // transfers other than the unused code
  bit          no_gaps = 1'b0;   // set for stretches of back-to-back items

  always #2 clk = ~clk;

  graph_bfs_dfs_search DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .node_index       (node_index),
    .node_value       (node_value),
    .neighbor_slot    (neighbor_slot),
    .neighbor_index   (neighbor_index),
    .neighbor_present (neighbor_present),
    .visit_strobe     (visit_strobe),
    .visit_index      (visit_index),
    .visit_value      (visit_value),
    .found            (found),
    .last             (last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Results hold for one full cycle, so the falling edge sees them settled.
  // Every strobe is a transfer: the receiver never stalls.
  always @(negedge clk) begin
    if (!rst && visit_strobe === 1'b1)
      walks.check_visit(visit_index, visit_value, found, last);
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a rising edge. Holds start until busy is low at the falling
  // edge, which means the transfer happens at the next rising edge. start
  // stays high when the next item follows without a gap.
  task automatic send_item(logic [1:0] rq, logic [IDX_W-1:0] ni,
                           logic signed [VAL_W-1:0] nv, logic sl,
                           logic [IDX_W-1:0] nbi, logic pr);
    int gap;
    start            <= 1'b1;
    req_type         <= rq;
    node_index       <= ni;
    node_value       <= nv;
    neighbor_slot    <= sl;
    neighbor_index   <= nbi;
    neighbor_present <= pr;
    do @(negedge clk); while (busy !== 1'b0);
    walks.accept_item(rq, ni, nv, sl, nbi, pr);
    @(posedge clk);
    if (rq != REQ_UNUSED) items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // unused fields carry random junk
  task automatic write_value(int idx, logic [31:0] v);
    logic [31:0] junk;
    junk = $urandom;
    send_item(REQ_VALUE, idx[IDX_W-1:0], v, junk[0], junk[12:8], junk[16]);
  endtask

  task automatic write_link(int idx, int sl, int nb, bit pr);
    logic [31:0] junk;
    junk = $urandom;
    send_item(REQ_LINK, idx[IDX_W-1:0], junk, sl[0], nb[IDX_W-1:0], pr);
  endtask

  // a search never reads a node whose value was never set
  task automatic run_search(int root);
    logic [31:0] junk;
    int          hole;
    hole = walks.unwritten_in_reach(root);
    while (hole >= 0) begin
      write_value(hole, $urandom);
      hole = walks.unwritten_in_reach(root);
    end
    junk = $urandom;
    send_item(REQ_SEARCH, root[IDX_W-1:0], junk, junk[3], junk[20:16], junk[24]);
  endtask

  // Drops start and waits until every visit has come out and busy is low.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (walks.expected_visits.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk);
  endtask

  // setup cycle, access cycle; the register takes the data at the edge
  // that ends the access cycle
  task automatic reg_write(logic [1:0] r, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    walks.set_reg(r, d);
    @(posedge clk);
  endtask

  task automatic set_config(bit m, logic [31:0] t, bit s);
    wait_idle();
    reg_write(REG_MODE, {31'd0, m});
    reg_write(REG_TARGET, t);
    reg_write(REG_STOP, {31'd0, s});
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin
    int          members [NODES];
    int          k, j, tmp, pick;
    logic [31:0] v, t;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small graph with a back edge, a self loop and an absent
    // slot ahead of a present one; extreme node values.
    write_value(0, 32'h7fff_ffff);
    write_value(1, 32'd5);
    write_value(2, 32'h8000_0000);
    write_value(31, 32'hffff_ffff);
    write_value(30, 32'd0);
    write_link(0, 0, 31, 1'b1);
    write_link(0, 1, 1, 1'b1);
    write_link(31, 0, 2, 1'b1);
    write_link(31, 1, 0, 1'b1);
    write_link(1, 0, 17, 1'b0);     // empty first slot ends the list...
    write_link(1, 1, 30, 1'b1);     // ...so this link is never followed
    write_link(2, 0, 30, 1'b1);
    write_link(30, 0, 30, 1'b1);
    send_item(REQ_UNUSED, 5'd9, 32'h1234_5678, 1'b1, 5'd3, 1'b1);
    run_search(0);                  // reset config: breadth-first, stops at 5
    run_search(30);                 // self loop, single visit
    set_config(MODE_DFS, 32'hffff_ffff, 1'b0);
    run_search(0);                  // match in the middle, walk goes on
    set_config(MODE_BFS, 32'h8000_0000, 1'b0);
    run_search(2);
    set_config(MODE_DFS, 32'h7fff_ffff, 1'b1);
    run_search(0);                  // root itself matches

    // Random: mostly a fresh graph on a few nodes followed by searches on
    // it, with now and then a burst of loose, unrelated items.
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: t = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
          1: t = $urandom;
          default: begin
            pick = $urandom_range(0, NODES - 1);
            while (!walks.written[pick]) pick = $urandom_range(0, NODES - 1);
            t = walks.node_val[pick];
          end
        endcase
        set_config($urandom_range(0, 1), t, $urandom_range(0, 1));
      end
      no_gaps = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 8)) begin
          v = $urandom;
          case ($urandom_range(0, 3))
            0: write_value(v[4:0], $urandom);
            1: write_link(v[4:0], v[5], v[12:8], v[16]);
            2: run_search(v[4:0]);
            default: send_item(REQ_UNUSED, v[4:0], $urandom, v[5], v[12:8], v[16]);
          endcase
        end
      end else begin
        foreach (members[i]) members[i] = i;
        for (int i = NODES - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = members[i];
          members[i] = members[j];
          members[j] = tmp;
        end
        // now and then the whole node set, for walks of full length
        k = ($urandom_range(0, 9) == 0) ? NODES : $urandom_range(2, 10);
        for (int i = 0; i < k; i++) begin
          v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom;
          write_value(members[i], v);
        end
        for (int i = 0; i < k; i++)
          for (int s = 0; s < DEGREE; s++)
            write_link(members[i], s, members[$urandom_range(0, k - 1)],
                       $urandom_range(0, 99) < (s == 0 ? 85 : 60));
        repeat ($urandom_range(1, 4)) run_search(members[$urandom_range(0, k - 1)]);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (walks.bad_visits == 0 && walks.expected_visits.size() == 0)
      $display("** graph_bfs_dfs_search: PASSED **");
    else
      $display("** graph_bfs_dfs_search: FAILED **");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("** graph_bfs_dfs_search: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gbs_pkg.sv
src/gbs_regs.sv
src/gbs_walk.sv
src/gbs_emit.sv
src/graph_bfs_dfs_search.sv
dv/testbench.sv
